### hdl/kpu_pkg.sv
// ============================================================================
// kpu_pkg: shared types and constants for the k-permutation unrank unit
// Field widths, register indexes, sequencer states and defaults.
// ============================================================================
package kpu_pkg;

    localparam int MAX_CELLS_DEF = 16;

    localparam int RANK_W      = 45;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CELL_IDX_W  = 4;
    localparam int PIECE_W     = 5;
    localparam int LOC_W       = 4;

    localparam logic [PIECE_W-1:0] EMPTY_PIECE = PIECE_W'(16);

    localparam logic [CFG_W-1:0] CELL_COUNT_RST     = CFG_W'(16);
    localparam logic [CFG_W-1:0] DISTINCT_COUNT_RST = CFG_W'(16);

    localparam int DIV_STEPS = RANK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_COUNT     = CFG_IDX_W'(0),
        CFG_DISTINCT_COUNT = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD_I,
        ST_RD_P,
        ST_WR_P,
        ST_WR_I,
        ST_OUT_RD,
        ST_OUT_SEND
    } state_t;

endpackage

### hdl/kpu_if.sv
// ============================================================================
// kpu_if: item channels of the k-permutation unrank unit
// Rank input channel and per-cell result channel, valid/ready handshake.
// ============================================================================
interface kpu_rank_if
    import kpu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_value;

    modport source (output valid, output rank_value, input ready);
    modport sink   (input valid, input rank_value, output ready);
endinterface

interface kpu_result_if
    import kpu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CELL_IDX_W-1:0] cell_index;
    logic [PIECE_W-1:0]    piece;
    logic [LOC_W-1:0]      location_entry;
    logic                  last;

    modport source (output valid, output cell_index, output piece,
                    output location_entry, output last, input ready);
    modport sink   (input valid, input cell_index, input piece,
                    input location_entry, input last, output ready);
endinterface

### hdl/k_permutation_unrank_unit.sv
// ============================================================================
// k_permutation_unrank_unit: expands a mixed-radix rank into a k-permutation
// Swap-based unranking over a location array, then one result per cell.
// ============================================================================
//  channel     | dir | handshake     | payload
//  rank_in     | in  | valid/ready   | rank_value[44:0]
//  result_out  | out | valid/ready   | cell_index, piece, location_entry, last
//  cfg         | in  | cfg_write_en  | cfg_index, cfg_data (cell/distinct count)
//
//  With the sink always ready, the bit-serial division per piece dominates the
//  time from accept to next accept. Location and cell memories are swept at the
//  start of each item. rank_in.ready is high only while idle; a stalled result
//  holds its item. Reset sets both counts to 16 and returns the sequencer to idle.
module k_permutation_unrank_unit
    import kpu_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    kpu_rank_if.sink             rank_in,
    kpu_result_if.source         result_out
);

    localparam int CW = $clog2(MAX_CELLS);
    localparam int NW = $clog2(MAX_CELLS + 1);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  cell_count_reg, distinct_count_reg;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     d_reg, d_next;
    logic [NW-1:0]     i_reg, i_next;
    logic [NW-1:0]     x_reg, x_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [CW-1:0]     part_reg, part_next;
    logic [CW-1:0]     loc_i_reg, loc_i_next;
    logic [CW-1:0]     loc_p_reg, loc_p_next;

    logic [CW-1:0]      loc_mem [MAX_CELLS];
    logic [PIECE_W-1:0] cell_mem [MAX_CELLS];
    logic [CW-1:0]      loc_rd_reg;
    logic [PIECE_W-1:0] cell_rd_reg;
    logic               loc_we, cell_we;
    logic [CW-1:0]      loc_waddr, loc_raddr, cell_waddr;
    logic [CW-1:0]      loc_wdata;
    logic [PIECE_W-1:0] cell_wdata;

    logic [CFG_W-1:0]  n_lo, n_sat;
    logic [NW-1:0]     n_in, d_in;
    logic              div_start, div_done;
    logic [NW-1:0]     divisor;
    logic [RANK_W-1:0] quotient;
    logic [NW-1:0]     remainder;
    logic [NW:0]       part_sum;
    logic              x_last;

    // clamp configured counts
    assign n_lo  = (cell_count_reg == '0) ? CFG_W'(1) : cell_count_reg;
    assign n_sat = (n_lo > CFG_W'(MAX_CELLS)) ? CFG_W'(MAX_CELLS) : n_lo;
    assign n_in  = NW'(n_sat);
    assign d_in  = (distinct_count_reg > n_sat) ? n_in : NW'(distinct_count_reg);

    assign divisor  = n_reg - i_reg;
    assign part_sum = {1'b0, i_reg} + {1'b0, remainder};
    assign x_last   = (x_reg == n_reg - NW'(1));

    kpu_div #(
        .DIVISOR_W (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rank_reg),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg     <= CELL_COUNT_RST;
            distinct_count_reg <= DISTINCT_COUNT_RST;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == CFG_CELL_COUNT)
            begin
                cell_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_DISTINCT_COUNT)
            begin
                distinct_count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        rank_next  = rank_reg;
        part_next  = part_reg;
        loc_i_next = loc_i_reg;
        loc_p_next = loc_p_reg;
        loc_we     = 1'b0;
        loc_waddr  = x_reg[CW-1:0];
        loc_wdata  = x_reg[CW-1:0];
        loc_raddr  = x_reg[CW-1:0];
        cell_we    = 1'b0;
        cell_waddr = x_reg[CW-1:0];
        cell_wdata = EMPTY_PIECE;
        div_start  = 1'b0;
        rank_in.ready    = 1'b0;
        result_out.valid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rank_in.ready = 1'b1;
                if (rank_in.valid)
                begin
                    rank_next  = rank_in.rank_value;
                    n_next     = n_in;
                    d_next     = d_in;
                    i_next     = '0;
                    x_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                loc_we  = 1'b1;
                cell_we = 1'b1;
                if (x_last)
                begin
                    x_next     = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    x_next = x_reg + NW'(1);
                end
            end
            ST_CHECK:
            begin
                state_next = (i_reg == d_reg) ? ST_OUT_RD : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    rank_next  = quotient;
                    part_next  = (part_sum >= {1'b0, n_reg})
                                 ? CW'(n_reg - NW'(1)) : CW'(part_sum);
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:
            begin
                loc_raddr  = i_reg[CW-1:0];
                state_next = ST_RD_P;
            end
            ST_RD_P:
            begin
                loc_i_next = loc_rd_reg;
                loc_raddr  = part_reg;
                state_next = ST_WR_P;
            end
            ST_WR_P:
            begin
                loc_p_next = loc_rd_reg;
                loc_we     = 1'b1;
                loc_waddr  = part_reg;
                loc_wdata  = loc_i_reg;
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                loc_we     = 1'b1;
                loc_waddr  = i_reg[CW-1:0];
                loc_wdata  = loc_p_reg;
                cell_we    = 1'b1;
                cell_waddr = loc_p_reg;
                cell_wdata = PIECE_W'(i_reg);
                i_next     = i_reg + NW'(1);
                state_next = ST_CHECK;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                result_out.valid = 1'b1;
                if (result_out.ready)
                begin
                    if (x_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        x_next     = x_reg + NW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            d_reg     <= '0;
            i_reg     <= '0;
            x_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            d_reg     <= d_next;
            i_reg     <= i_next;
            x_reg     <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= rank_next;
        part_reg  <= part_next;
        loc_i_reg <= loc_i_next;
        loc_p_reg <= loc_p_next;
    end

    // location and cell memories
    always_ff @(posedge clk)
    begin
        if (loc_we)
        begin
            loc_mem[loc_waddr] <= loc_wdata;
        end
        loc_rd_reg <= loc_mem[loc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rd_reg <= cell_mem[x_reg[CW-1:0]];
    end

    assign result_out.cell_index     = CELL_IDX_W'(x_reg);
    assign result_out.piece          = cell_rd_reg;
    assign result_out.location_entry = LOC_W'(loc_rd_reg);
    assign result_out.last           = x_last;

endmodule

### hdl/kpu_div.sv
// ============================================================================
// kpu_div: iterative restoring divider
// Divides the 45-bit rank by a small radix, one quotient bit per cycle.
// ============================================================================
module kpu_div
    import kpu_pkg::*;
#(
    parameter int DIVISOR_W = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RANK_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [RANK_W-1:0]    quotient,
    output logic [DIVISOR_W-1:0] remainder
);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [RANK_W-1:0]    quo_reg,   quo_next;
    logic [DIVISOR_W-1:0] rem_reg,   rem_next;
    logic [DIVISOR_W-1:0] dvs_reg,   dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[RANK_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[RANK_W-2:0], ge};
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### test/tb_k_permutation_unrank_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_k_permutation_unrank_unit: self-checking bench for the unrank unit
// A directed table sweeps the count extremes and rank boundaries, then random
// phases reconfigure the unit and send ranks, all but the last under random
// handshake stalls. Untyped rows go to an in-bench swap-unranking predictor.
// ============================================================================
module tb_k_permutation_unrank_unit;
    import kpu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(2);
    localparam logic [RANK_W-1:0]    RANK_ONES       = '1;
    localparam logic [RANK_W-1:0]    RANK_16_FACT_M1 = RANK_W'(64'd20922789887999);
    localparam int N_DIRECTED   = 22;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 14;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_index;
        logic [PIECE_W-1:0]    piece;
        logic [LOC_W-1:0]      location_entry;
        logic                  last;
    } cell_result_t;

    // typed rows: identity layout, pieces 0..placed-1 sit in their home cells
    typedef struct packed {
        logic [CFG_W-1:0]  cells;
        logic [CFG_W-1:0]  distinct;
        logic [RANK_W-1:0] rank;
        logic              typed;
        logic [CFG_W-1:0]  known_cells;
        logic [CFG_W-1:0]  known_placed;
    } stim_row_t;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{5'd16, 5'd16, RANK_W'(0),               1'b1, 5'd16, 5'd16},
        '{5'd16, 5'd16, RANK_16_FACT_M1,          1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd16, RANK_ONES,                1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd16, RANK_W'(1),               1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd0,  RANK_W'(45'h0AAA_AAAA_AAAA), 1'b1, 5'd16, 5'd0},
        '{5'd16, 5'd0,  RANK_ONES,                1'b1, 5'd16, 5'd0},
        '{5'd1,  5'd1,  RANK_ONES,                1'b1, 5'd1,  5'd1},
        '{5'd0,  5'd5,  RANK_W'(45'h1_2345_6789), 1'b1, 5'd1,  5'd1},
        '{5'd31, 5'd31, RANK_W'(45'h0AAA_AAAA_AAAA), 1'b0, 5'd0, 5'd0},
        '{5'd31, 5'd31, RANK_W'(0),               1'b1, 5'd16, 5'd16},
        '{5'd2,  5'd2,  RANK_W'(1),               1'b0, 5'd0,  5'd0},
        '{5'd2,  5'd2,  RANK_W'(0),               1'b1, 5'd2,  5'd2},
        '{5'd5,  5'd3,  RANK_W'(59),              1'b0, 5'd0,  5'd0},
        '{5'd5,  5'd3,  RANK_W'(60),              1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd1,  RANK_W'(15),              1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd8,  RANK_W'(0),               1'b1, 5'd16, 5'd8},
        '{5'd16, 5'd8,  RANK_W'(518918399),       1'b0, 5'd0,  5'd0},
        '{5'd7,  5'd20, RANK_W'(5039),            1'b0, 5'd0,  5'd0},
        '{5'd7,  5'd20, RANK_W'(5040),            1'b0, 5'd0,  5'd0},
        '{5'd16, 5'd17, RANK_W'(45'h1555_5555_5555), 1'b0, 5'd0, 5'd0},
        '{5'd3,  5'd0,  RANK_ONES,                1'b1, 5'd3,  5'd0},
        '{5'd16, 5'd15, RANK_16_FACT_M1,          1'b0, 5'd0,  5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    kpu_rank_if   rank_in ();
    kpu_result_if result_out ();

    k_permutation_unrank_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rank_in      (rank_in),
        .result_out   (result_out)
    );

    always #5 clk = ~clk;

    cell_result_t     expected_cells [$];
    logic [CFG_W-1:0] cur_cells;
    logic [CFG_W-1:0] cur_distinct;
    int               errors;
    bit               calm;
    int               hold_cnt;
    int               run_cnt;

    function automatic int eff_cells();
        int n;
        n = int'(cur_cells);
        if (n == 0)
            n = 1;
        if (n > MAX_CELLS_DEF)
            n = MAX_CELLS_DEF;
        return n;
    endfunction

    function automatic int eff_pieces();
        int d;
        d = int'(cur_distinct);
        if (d > eff_cells())
            d = eff_cells();
        return d;
    endfunction

    task automatic expect_unranked(input logic [RANK_W-1:0] rank);
        logic [LOC_W-1:0]   loc [MAX_CELLS_DEF];
        logic [PIECE_W-1:0] held [MAX_CELLS_DEF];
        logic [LOC_W-1:0]   swap_tmp;
        logic [63:0]        rem;
        logic [63:0]        radix;
        int                 n;
        int                 d;
        int                 partner;
        n = eff_cells();
        d = eff_pieces();
        for (int x = 0; x < n; x++)
        begin
            loc[x]  = LOC_W'(x);
            held[x] = EMPTY_PIECE;
        end
        rem = 64'(rank);
        for (int i = 0; i < d; i++)
        begin
            radix   = 64'(n - i);
            partner = i + int'(rem % radix);
            if (partner > n - 1)
                partner = n - 1;
            swap_tmp     = loc[partner];
            loc[partner] = loc[i];
            loc[i]       = swap_tmp;
            rem          = rem / radix;
            held[loc[i]] = PIECE_W'(i);
        end
        for (int x = 0; x < n; x++)
            expected_cells.push_back(cell_result_t'{CELL_IDX_W'(x), held[x], loc[x],
                                                   x == n - 1});
    endtask

    task automatic expect_identity(input int n, input int placed);
        for (int x = 0; x < n; x++)
            expected_cells.push_back(cell_result_t'{CELL_IDX_W'(x),
                                       (x < placed) ? PIECE_W'(x) : EMPTY_PIECE,
                                       LOC_W'(x), x == n - 1});
    endtask

    function automatic logic [RANK_W-1:0] pick_rank();
        logic [63:0] span;
        logic [63:0] raw;
        logic [63:0] pick;
        span = 64'd1;
        for (int i = 0; i < eff_pieces(); i++)
            span = span * 64'(eff_cells() - i);
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1, 2: pick = raw % span;
            3:       pick = raw;
            4:       pick = span - 64'd1;
            default: pick = span + (raw % 64'd4);
        endcase
        return RANK_W'(pick);
    endfunction

    task automatic send_rank(input stim_row_t row);
        rank_in.valid      <= 1'b1;
        rank_in.rank_value <= row.rank;
        do
            @(posedge clk);
        while (!rank_in.ready);
        if (row.typed)
            expect_identity(int'(row.known_cells), int'(row.known_placed));
        else
            expect_unranked(row.rank);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            rank_in.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic drain();
        rank_in.valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_counts(input logic [CFG_W-1:0] cells, input logic [CFG_W-1:0] distinct);
        drain();
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_CELL_COUNT;
        cfg_data     <= cells;
        @(posedge clk);
        cfg_index    <= CFG_DISTINCT_COUNT;
        cfg_data     <= distinct;
        @(posedge clk);
        // spare index: must not disturb either count
        cfg_index    <= CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_SPARE_FIRST));
        cfg_data     <= CFG_W'($urandom);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_cells    = cells;
        cur_distinct = distinct;
    endtask

    task automatic check_cell();
        cell_result_t want;
        if (expected_cells.size() == 0)
        begin
            $error("unexpected result item: cell_index %0d", result_out.cell_index);
            errors++;
        end
        else
        begin
            want = expected_cells.pop_front();
            if (result_out.cell_index !== want.cell_index)
            begin
                $error("cell_index: expected %0d, actual %0d",
                       want.cell_index, result_out.cell_index);
                errors++;
            end
            if (result_out.piece !== want.piece)
            begin
                $error("piece: expected %0d, actual %0d", want.piece, result_out.piece);
                errors++;
            end
            if (result_out.location_entry !== want.location_entry)
            begin
                $error("location_entry: expected %0d, actual %0d",
                       want.location_entry, result_out.location_entry);
                errors++;
            end
            if (result_out.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, result_out.last);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
            check_cell();
        if (calm)
            result_out.ready <= 1'b1;
        else if (hold_cnt > 0)
        begin
            result_out.ready <= 1'b0;
            hold_cnt--;
        end
        else if (run_cnt > 0)
        begin
            result_out.ready <= 1'b1;
            run_cnt--;
        end
        else
        begin
            result_out.ready <= 1'b0;
            hold_cnt = $urandom_range(0, 9);
            run_cnt  = $urandom_range(0, 24);
        end
    end

    initial
    begin
        stim_row_t row;
        int        n_rand;
        errors             = 0;
        calm               = 1'b0;
        hold_cnt           = 0;
        run_cnt            = 0;
        cur_cells          = CELL_COUNT_RST;
        cur_distinct       = DISTINCT_COUNT_RST;
        rst_n              <= 1'b0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= CFG_CELL_COUNT;
        cfg_data           <= '0;
        rank_in.valid      <= 1'b0;
        rank_in.rank_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            if (row.cells != cur_cells || row.distinct != cur_distinct)
                set_counts(row.cells, row.distinct);
            send_rank(row);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == N_PHASES - 1)
            begin
                set_counts(CELL_COUNT_RST, DISTINCT_COUNT_RST);
                calm = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    row.cells = ($urandom_range(0, 1) == 0) ? CFG_W'(0)
                                : CFG_W'($urandom_range(17, 31));
                else
                    row.cells = CFG_W'($urandom_range(1, 16));
                row.distinct = CFG_W'($urandom_range(0, 31));
                if ($urandom_range(0, 1) == 0 && row.distinct > row.cells)
                    row.distinct = CFG_W'($urandom_range(0, int'(row.cells)));
                set_counts(row.cells, row.distinct);
            end
            n_rand = PHASE_ITEMS;
            for (int k = 0; k < n_rand; k++)
            begin
                row.typed = 1'b0;
                row.rank  = pick_rank();
                send_rank(row);
            end
        end

        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
